/* hdl/qsl_pkg.sv */
// Shared types and constants for the query string lexer.
// Used by qsl_core, qsl_rbuf, query_string_lexer and the testbench; depends on nothing.
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int MAX_FIELD_LEN_DEF = 256;
    localparam int CHAR_W            = 16;
    localparam int TOK_W             = 5;
    localparam int ERR_W             = 3;
    // Output tdata: char_valid, out_char, token_end, token_type, error_code.
    localparam int RES_BITS          = 1 + CHAR_W + 1 + TOK_W + ERR_W;
    localparam int M_TDATA_W         = ((RES_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W         = ((CHAR_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TERM,
        MODE_ESC,
        MODE_SLOP,
        MODE_QUOTE,
        MODE_RIN,
        MODE_REX,
        MODE_ERR
    } t_mode;

    typedef enum logic [TOK_W-1:0] {
        TOK_PLUS    = 5'd0,
        TOK_MINUS   = 5'd1,
        TOK_LPAREN  = 5'd2,
        TOK_RPAREN  = 5'd3,
        TOK_COLON   = 5'd4,
        TOK_NOT     = 5'd5,
        TOK_CARAT   = 5'd6,
        TOK_SLOP    = 5'd7,
        TOK_FUZZY   = 5'd8,
        TOK_QUOTED  = 5'd9,
        TOK_RANGEIN = 5'd10,
        TOK_RANGEEX = 5'd11,
        TOK_TERM    = 5'd12,
        TOK_NUMBER  = 5'd13,
        TOK_WILD    = 5'd14,
        TOK_PREFIX  = 5'd15,
        TOK_AND     = 5'd16,
        TOK_OR      = 5'd17,
        TOK_EOF     = 5'd18
    } t_tok;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_CHAR  = 3'd1,
        ERR_OPEN_RIN  = 3'd2,
        ERR_OPEN_REX  = 3'd3,
        ERR_OPEN_STR  = 3'd4,
        ERR_BAD_ESC   = 3'd5
    } t_err;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] out_char;
        logic              token_end;
        t_tok              token_type;
        t_err              error_code;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic       can_take;
        logic [1:0] count;
    } t_buf_status;

endpackage

/* hdl/query_string_lexer.sv */
// Query string lexer: one character per transaction in, token text and types out.
// Accepted items are registered; their results go on through the result register.
// Throughput: one item per cycle while m_axis is ready and each gives at most one
// result; an item with two results holds the result register until both leave.
// Reset: synchronous, active low; lexer goes idle, both registers empty.
// Depends on qsl_pkg, qsl_core and qsl_rbuf.
`timescale 1ns / 1ps

module query_string_lexer #(
    parameter int MAX_FIELD_LEN = qsl_pkg::MAX_FIELD_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qsl_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [15:0] char_code
    input  logic                           s_axis_tuser,  // [0] req_type
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] char_valid, [16:1] out_char, [17] token_end, [22:18] token_type,
    // [25:23] error_code, upper bits zero
    output logic [qsl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast   // last_result
);

    logic                        r_in_valid;
    logic                        r_in_req;
    logic [qsl_pkg::CHAR_W-1:0]  r_in_char;
    logic                        w_adv;

    qsl_pkg::t_result            w_res0, w_res1, w_out;
    logic [1:0]                  w_count;
    qsl_pkg::t_mode              w_mode;
    qsl_pkg::t_buf_status        w_buf_st;

    assign w_adv         = r_in_valid && w_buf_st.can_take;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req  <= s_axis_tuser;
            r_in_char <= s_axis_tdata[qsl_pkg::CHAR_W-1:0];
        end
    end

    qsl_core #(
        .MAX_FIELD_LEN(MAX_FIELD_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_req   (r_in_req),
        .i_char  (r_in_char),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_count (w_count),
        .o_mode  (w_mode)
    );

    qsl_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_adv),
        .i_wr_count (w_count),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_res      (w_out),
        .o_status   (w_buf_st)
    );

    assign m_axis_tdata = {{(qsl_pkg::M_TDATA_W - qsl_pkg::RES_BITS){1'b0}},
                           w_out.error_code, w_out.token_type, w_out.token_end,
                           w_out.out_char, w_out.char_valid};
    assign m_axis_tlast = w_out.last_result;

    a_buf_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_buf_st.count <= 2'd2)
        else $error("result register holds more than two results");

    a_end_item_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_req) |=> (w_mode == qsl_pkg::MODE_IDLE))
        else $error("lexer not idle after end of query");

    a_end_item_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_req) |-> (w_count != 2'd0))
        else $error("end of query produced no result");

    a_output_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_count != 2'd0) |=> m_axis_tvalid)
        else $error("results of a processed item are not presented");

endmodule

/* hdl/qsl_core.sv */
// Lexer state registers and the single-pass step logic for one item.
// Produces up to two results per item. Depends on qsl_pkg.
`timescale 1ns / 1ps

module qsl_core #(
    parameter int MAX_FIELD_LEN = qsl_pkg::MAX_FIELD_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_req,
    input  logic [qsl_pkg::CHAR_W-1:0]  i_char,
    output qsl_pkg::t_result            o_res0,
    output qsl_pkg::t_result            o_res1,
    output logic [1:0]                  o_count,
    output qsl_pkg::t_mode              o_mode
);

    localparam int SLOP_W = $clog2(MAX_FIELD_LEN - 1);
    localparam logic [SLOP_W-1:0] SLOP_MAX = SLOP_W'(MAX_FIELD_LEN - 2);

    typedef struct packed {
        logic [1:0]                 star;
        logic                       quest;
        logic                       alpha;
        logic [qsl_pkg::CHAR_W-1:0] final_ch;
        logic [4:0]                 kt_live;
        logic [2:0]                 kt_len;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{star: 2'd0, quest: 1'b0, alpha: 1'b0,
                                       final_ch: '0, kt_live: 5'h1F, kt_len: 3'd0};

    function automatic logic f_alpha(input logic [15:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
    endfunction

    function automatic logic f_digit(input logic [15:0] c);
        return c >= 16'h0030 && c <= 16'h0039;
    endfunction

    function automatic logic f_space(input logic [15:0] c);
        return c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D);
    endfunction

    // Tab, newline, space and the operator characters end a term.
    function automatic logic f_term_end(input logic [15:0] c);
        return c inside {16'h000A, 16'h0009, 16'h0020, 16'h002B, 16'h002D, 16'h0021,
                         16'h0028, 16'h0029, 16'h003A, 16'h005E, 16'h005B, 16'h005D,
                         16'h007B, 16'h007D, 16'h007E, 16'h0022};
    endfunction

    function automatic logic f_escapable(input logic [15:0] c);
        return c inside {16'h005C, 16'h002B, 16'h002D, 16'h0021, 16'h0028, 16'h0029,
                         16'h003A, 16'h005E, 16'h005B, 16'h005D, 16'h007B, 16'h007D,
                         16'h0022, 16'h007E, 16'h002A};
    endfunction

    // Keyword candidates by bit: AND, OR, NOT, "&&", "||".
    function automatic t_flags f_feed(input t_flags f, input logic [15:0] c);
        t_flags     r;
        logic [15:0] up;
        logic [4:0]  m;
        r  = f;
        up = (c >= 16'h0061 && c <= 16'h007A) ? c - 16'd32 : c;
        case (f.kt_len)
            3'd0: m = {up == 16'h007C, up == 16'h0026, up == 16'h004E,
                       up == 16'h004F, up == 16'h0041};
            3'd1: m = {up == 16'h007C, up == 16'h0026, up == 16'h004F,
                       up == 16'h0052, up == 16'h004E};
            3'd2: m = {1'b0, 1'b0, up == 16'h0054, 1'b0, up == 16'h0044};
            default: m = 5'b0;
        endcase
        if (f.kt_len < 3'd4) begin
            r.kt_live = f.kt_live & m;
            r.kt_len  = f.kt_len + 3'd1;
        end else begin
            r.kt_live = 5'b0;
        end
        if (f_alpha(c)) begin
            r.alpha = 1'b1;
        end
        r.final_ch = c;
        return r;
    endfunction

    function automatic qsl_pkg::t_result f_echo(input logic [15:0] c);
        qsl_pkg::t_result r;
        r            = '0;
        r.char_valid = 1'b1;
        r.out_char   = c;
        return r;
    endfunction

    function automatic qsl_pkg::t_result f_close(input qsl_pkg::t_tok t);
        qsl_pkg::t_result r;
        r            = '0;
        r.token_end  = 1'b1;
        r.token_type = t;
        return r;
    endfunction

    function automatic qsl_pkg::t_result f_fail(input qsl_pkg::t_err e);
        qsl_pkg::t_result r;
        r            = '0;
        r.error_code = e;
        return r;
    endfunction

    qsl_pkg::t_mode    r_mode, n_mode;
    t_flags            r_fl, n_fl;
    logic [SLOP_W-1:0] r_slop, n_slop;

    qsl_pkg::t_tok     w_class;
    qsl_pkg::t_tok     w_slop_tok;
    logic              w_and, w_or, w_not;
    t_flags            w_feed;

    logic              st_emit;
    logic              st_term;
    qsl_pkg::t_result  st_res;
    qsl_pkg::t_mode    st_mode;
    t_flags            st_fl;

    qsl_pkg::t_result  w_res0, w_res1;
    logic [1:0]        w_count;

    // Term classification from the running flags.
    always_comb begin
        w_and = (r_fl.kt_live[0] && r_fl.kt_len == 3'd3) ||
                (r_fl.kt_live[3] && r_fl.kt_len == 3'd2);
        w_or  = (r_fl.kt_live[1] && r_fl.kt_len == 3'd2) ||
                (r_fl.kt_live[4] && r_fl.kt_len == 3'd2);
        w_not = r_fl.kt_live[2] && r_fl.kt_len == 3'd3;
        if (r_fl.quest) begin
            w_class = qsl_pkg::TOK_WILD;
        end else if (r_fl.star == 2'd1 && r_fl.final_ch == 16'h002A) begin
            w_class = qsl_pkg::TOK_PREFIX;
        end else if (r_fl.star != 2'd0) begin
            w_class = qsl_pkg::TOK_WILD;
        end else if (w_and) begin
            w_class = qsl_pkg::TOK_AND;
        end else if (w_or) begin
            w_class = qsl_pkg::TOK_OR;
        end else if (w_not) begin
            w_class = qsl_pkg::TOK_NOT;
        end else begin
            w_class = r_fl.alpha ? qsl_pkg::TOK_TERM : qsl_pkg::TOK_NUMBER;
        end
        w_slop_tok = (r_slop != '0) ? qsl_pkg::TOK_SLOP : qsl_pkg::TOK_FUZZY;
        w_feed     = f_feed(r_fl, i_char);
    end

    // Handling of a character that opens a token.
    always_comb begin
        st_emit = 1'b1;
        st_term = 1'b0;
        st_res  = f_echo(i_char);
        st_mode = qsl_pkg::MODE_IDLE;
        if (f_space(i_char)) begin
            st_emit = 1'b0;
        end else begin
            case (i_char)
                16'h002B: st_res = f_close(qsl_pkg::TOK_PLUS);
                16'h002D: st_res = f_close(qsl_pkg::TOK_MINUS);
                16'h0028: st_res = f_close(qsl_pkg::TOK_LPAREN);
                16'h0029: st_res = f_close(qsl_pkg::TOK_RPAREN);
                16'h003A: st_res = f_close(qsl_pkg::TOK_COLON);
                16'h0021: st_res = f_close(qsl_pkg::TOK_NOT);
                16'h005E: st_res = f_close(qsl_pkg::TOK_CARAT);
                16'h007E: st_mode = qsl_pkg::MODE_SLOP;
                16'h0022: st_mode = qsl_pkg::MODE_QUOTE;
                16'h005B: st_mode = qsl_pkg::MODE_RIN;
                16'h007B: st_mode = qsl_pkg::MODE_REX;
                16'h005D, 16'h007D, 16'h002A: begin
                    st_res  = f_fail(qsl_pkg::ERR_BAD_CHAR);
                    st_mode = qsl_pkg::MODE_ERR;
                end
                default: begin
                    st_term = 1'b1;
                    st_mode = (i_char == 16'h005C) ? qsl_pkg::MODE_ESC
                                                   : qsl_pkg::MODE_TERM;
                end
            endcase
        end
        // Operator characters carry the echo and the close in one result.
        if (st_res.token_end) begin
            st_res.char_valid = 1'b1;
            st_res.out_char   = i_char;
        end
        st_fl = r_fl;
        if (st_term) begin
            st_fl       = f_feed(FLAGS_RESET, i_char);
            st_fl.quest = (i_char == 16'h003F);
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_fl    = r_fl;
        n_slop  = r_slop;
        w_res0  = '0;
        w_res1  = '0;
        w_count = 2'd0;
        if (i_req) begin
            w_res1  = f_close(qsl_pkg::TOK_EOF);
            w_count = 2'd2;
            case (r_mode)
                qsl_pkg::MODE_TERM:  w_res0 = f_close(w_class);
                qsl_pkg::MODE_SLOP:  w_res0 = f_close(w_slop_tok);
                qsl_pkg::MODE_QUOTE: w_res0 = f_fail(qsl_pkg::ERR_OPEN_STR);
                qsl_pkg::MODE_RIN:   w_res0 = f_fail(qsl_pkg::ERR_OPEN_RIN);
                qsl_pkg::MODE_REX:   w_res0 = f_fail(qsl_pkg::ERR_OPEN_REX);
                qsl_pkg::MODE_ESC:   w_res0 = f_fail(qsl_pkg::ERR_BAD_ESC);
                default: begin
                    w_res0  = f_close(qsl_pkg::TOK_EOF);
                    w_count = 2'd1;
                end
            endcase
            n_mode = qsl_pkg::MODE_IDLE;
            n_fl   = FLAGS_RESET;
            n_slop = '0;
        end else begin
            case (r_mode)
                qsl_pkg::MODE_IDLE: begin
                    w_res0  = st_res;
                    w_count = {1'b0, st_emit};
                    n_mode  = st_mode;
                    n_fl    = st_fl;
                    n_slop  = '0;
                end
                qsl_pkg::MODE_TERM: begin
                    if (f_term_end(i_char)) begin
                        w_res0  = f_close(w_class);
                        w_res1  = st_res;
                        w_count = st_emit ? 2'd2 : 2'd1;
                        n_mode  = st_mode;
                        n_fl    = st_fl;
                        n_slop  = '0;
                    end else begin
                        n_fl = w_feed;
                        if (i_char == 16'h002A && r_fl.star != 2'd2) begin
                            n_fl.star = r_fl.star + 2'd1;
                        end
                        if (i_char == 16'h003F) begin
                            n_fl.quest = 1'b1;
                        end
                        if (i_char == 16'h005C) begin
                            n_mode = qsl_pkg::MODE_ESC;
                        end
                        w_res0  = f_echo(i_char);
                        w_count = 2'd1;
                    end
                end
                qsl_pkg::MODE_ESC: begin
                    w_count = 2'd1;
                    if (f_escapable(i_char)) begin
                        n_fl   = w_feed;
                        w_res0 = f_echo(i_char);
                        n_mode = qsl_pkg::MODE_TERM;
                    end else begin
                        w_res0 = f_fail(qsl_pkg::ERR_BAD_ESC);
                        n_mode = qsl_pkg::MODE_ERR;
                    end
                end
                qsl_pkg::MODE_SLOP: begin
                    if (f_digit(i_char) && r_slop < SLOP_MAX) begin
                        n_slop  = r_slop + SLOP_W'(1);
                        w_res0  = f_echo(i_char);
                        w_count = 2'd1;
                    end else begin
                        w_res0  = f_close(w_slop_tok);
                        w_res1  = st_res;
                        w_count = st_emit ? 2'd2 : 2'd1;
                        n_mode  = st_mode;
                        n_fl    = st_fl;
                        n_slop  = '0;
                    end
                end
                qsl_pkg::MODE_QUOTE, qsl_pkg::MODE_RIN, qsl_pkg::MODE_REX: begin
                    w_res0  = f_echo(i_char);
                    w_count = 2'd1;
                    if ((r_mode == qsl_pkg::MODE_QUOTE && i_char == 16'h0022) ||
                        (r_mode == qsl_pkg::MODE_RIN && i_char == 16'h005D) ||
                        (r_mode == qsl_pkg::MODE_REX && i_char == 16'h007D)) begin
                        w_res0.token_end  = 1'b1;
                        w_res0.token_type = (r_mode == qsl_pkg::MODE_QUOTE)
                                          ? qsl_pkg::TOK_QUOTED
                                          : ((r_mode == qsl_pkg::MODE_RIN)
                                             ? qsl_pkg::TOK_RANGEIN
                                             : qsl_pkg::TOK_RANGEEX);
                        n_mode = qsl_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    // Error state: characters are dropped until the end item.
                end
            endcase
        end
        if (w_count == 2'd2) begin
            w_res1.last_result = 1'b1;
        end else begin
            w_res0.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qsl_pkg::MODE_IDLE;
            r_fl   <= FLAGS_RESET;
            r_slop <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_fl   <= n_fl;
            r_slop <= n_slop;
        end
    end

    assign o_res0  = w_res0;
    assign o_res1  = w_res1;
    assign o_count = w_count;
    assign o_mode  = r_mode;

endmodule

/* hdl/qsl_rbuf.sv */
// Two-entry result register between the lexer step and the output stream.
// Holds every result of one item and hands them out in order. Depends on qsl_pkg.
`timescale 1ns / 1ps

module qsl_rbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [1:0]            i_wr_count,
    input  qsl_pkg::t_result      i_res0,
    input  qsl_pkg::t_result      i_res1,
    input  logic                  i_ready,
    output logic                  o_valid,
    output qsl_pkg::t_result      o_res,
    output qsl_pkg::t_buf_status  o_status
);

    logic [1:0]       r_cnt;
    qsl_pkg::t_result r_e0, r_e1;
    logic             w_pop;

    assign o_valid          = (r_cnt != 2'd0);
    assign w_pop            = o_valid && i_ready;
    assign o_res            = r_e0;
    assign o_status.count   = r_cnt;
    // A new item may enter once the last waiting result leaves in this cycle.
    assign o_status.can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_wr) begin
            r_cnt <= i_wr_count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_e0 <= i_res0;
            r_e1 <= i_res1;
        end else if (w_pop && r_cnt == 2'd2) begin
            r_e0 <= r_e1;
        end
    end

endmodule

/* sim/query_string_lexer_tb.sv */
// Self-checking testbench for query_string_lexer: directed and random queries in,
// token results checked against a behavioral lexer kept inside the testbench.
// Depends on qsl_pkg and the query_string_lexer RTL.
`timescale 1ns / 1ps

module query_string_lexer_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [qsl_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;   // [15:0] char_code
    logic                          s_axis_tuser = 1'b0; // [0] req_type
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b1;
    // [0] char_valid, [16:1] out_char, [17] token_end, [22:18] token_type,
    // [25:23] error_code, upper bits zero
    logic [qsl_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;

    query_string_lexer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Lexer state mirrored by the testbench.
    qsl_pkg::t_mode lx_mode  = qsl_pkg::MODE_IDLE;
    logic [1:0]     lx_stars = '0;
    logic           lx_qmark = 1'b0;
    logic           lx_alpha = 1'b0;
    logic [15:0]    lx_final = '0;
    logic [2:0]     kw_len   = '0;
    logic [4:0]     kw_live  = '1;
    logic [7:0]     slop_cnt = '0;

    qsl_pkg::t_result tokens_due[$];
    int      miss_count  = 0;
    int      live_items  = 0;
    int      cycle_count = 0;
    int      stall_left  = 0;
    logic    bursts_on   = 1'b0;

    // ---------------------------------------------------------------- lexer

    function automatic void put(logic cv, logic [15:0] ch, logic te, qsl_pkg::t_tok tt,
                                qsl_pkg::t_err er);
        qsl_pkg::t_result r;
        r.char_valid  = cv;
        r.out_char    = ch;
        r.token_end   = te;
        r.token_type  = tt;
        r.error_code  = er;
        r.last_result = 1'b0;
        tokens_due = {tokens_due, r};
    endfunction

    // The type field reads zero whenever no token closes.
    function automatic void echo(logic [15:0] c);
        put(1'b1, c, 1'b0, qsl_pkg::TOK_PLUS, qsl_pkg::ERR_NONE);
    endfunction

    function automatic void close_tok(qsl_pkg::t_tok t);
        put(1'b0, 16'h0000, 1'b1, t, qsl_pkg::ERR_NONE);
    endfunction

    function automatic void flag_err(qsl_pkg::t_err e);
        put(1'b0, 16'h0000, 1'b0, qsl_pkg::TOK_PLUS, e);
    endfunction

    function automatic logic is_space(logic [15:0] c);
        return c == 16'd32 || (c >= 16'd9 && c <= 16'd13);
    endfunction

    function automatic logic is_alpha(logic [15:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_term_end(logic [15:0] c);
        case (c)
            "\n", "\t", " ", "+", "-", "!", "(", ")", ":", "^",
            "[", "]", "{", "}", "~", "\"": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_escapable(logic [15:0] c);
        case (c)
            "\\", "+", "-", "!", "(", ")", ":", "^", "[", "]",
            "{", "}", "\"", "~", "*": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Keyword candidates: 0 AND, 1 OR, 2 NOT, 3 &&, 4 ||.
    function automatic int kw_size(int k);
        return (k == 0 || k == 2) ? 3 : 2;
    endfunction

    function automatic logic [15:0] kw_char(int k, int p);
        string w;
        case (k)
            0: w = "AND";
            1: w = "OR";
            2: w = "NOT";
            3: w = "&&";
            default: w = "||";
        endcase
        return {8'h00, w[p]};
    endfunction

    function automatic logic kw_hit(int k);
        return kw_live[k] && kw_len == kw_size(k);
    endfunction

    function automatic void clear_term();
        lx_stars = '0;
        lx_qmark = 1'b0;
        lx_alpha = 1'b0;
        lx_final = '0;
        kw_len   = '0;
        kw_live  = '1;
    endfunction

    function automatic void lex_reset();
        lx_mode  = qsl_pkg::MODE_IDLE;
        slop_cnt = '0;
        clear_term();
    endfunction

    function automatic void feed(logic [15:0] c);
        logic [15:0] up;
        int k;
        up = (c >= "a" && c <= "z") ? c - 16'd32 : c;
        if (kw_len < 3'd4) begin
            for (k = 0; k < 5; k++)
                if (kw_len >= kw_size(k) || up != kw_char(k, kw_len))
                    kw_live[k] = 1'b0;
            kw_len = kw_len + 3'd1;
        end else begin
            kw_live = '0;
        end
        if (is_alpha(c))
            lx_alpha = 1'b1;
        lx_final = c;
    endfunction

    function automatic qsl_pkg::t_tok classify();
        if (lx_qmark)
            return qsl_pkg::TOK_WILD;
        if (lx_stars == 2'd1 && lx_final == "*")
            return qsl_pkg::TOK_PREFIX;
        if (lx_stars != 2'd0)
            return qsl_pkg::TOK_WILD;
        if (kw_hit(0) || kw_hit(3))
            return qsl_pkg::TOK_AND;
        if (kw_hit(1) || kw_hit(4))
            return qsl_pkg::TOK_OR;
        if (kw_hit(2))
            return qsl_pkg::TOK_NOT;
        return lx_alpha ? qsl_pkg::TOK_TERM : qsl_pkg::TOK_NUMBER;
    endfunction

    function automatic void start_char(logic [15:0] c);
        if (is_space(c))
            return;
        case (c)
            "+": put(1'b1, c, 1'b1, qsl_pkg::TOK_PLUS, qsl_pkg::ERR_NONE);
            "-": put(1'b1, c, 1'b1, qsl_pkg::TOK_MINUS, qsl_pkg::ERR_NONE);
            "(": put(1'b1, c, 1'b1, qsl_pkg::TOK_LPAREN, qsl_pkg::ERR_NONE);
            ")": put(1'b1, c, 1'b1, qsl_pkg::TOK_RPAREN, qsl_pkg::ERR_NONE);
            ":": put(1'b1, c, 1'b1, qsl_pkg::TOK_COLON, qsl_pkg::ERR_NONE);
            "!": put(1'b1, c, 1'b1, qsl_pkg::TOK_NOT, qsl_pkg::ERR_NONE);
            "^": put(1'b1, c, 1'b1, qsl_pkg::TOK_CARAT, qsl_pkg::ERR_NONE);
            "~": begin
                echo(c);
                slop_cnt = '0;
                lx_mode  = qsl_pkg::MODE_SLOP;
            end
            "\"": begin
                echo(c);
                lx_mode = qsl_pkg::MODE_QUOTE;
            end
            "[": begin
                echo(c);
                lx_mode = qsl_pkg::MODE_RIN;
            end
            "{": begin
                echo(c);
                lx_mode = qsl_pkg::MODE_REX;
            end
            "]", "}", "*": begin
                flag_err(qsl_pkg::ERR_BAD_CHAR);
                lx_mode = qsl_pkg::MODE_ERR;
            end
            default: begin
                clear_term();
                feed(c);
                echo(c);
                lx_mode = (c == "\\") ? qsl_pkg::MODE_ESC : qsl_pkg::MODE_TERM;
                if (c == "?")
                    lx_qmark = 1'b1;
            end
        endcase
    endfunction

    // Appends the results of one accepted transaction to tokens_due.
    function automatic void lex_step(logic is_end, logic [15:0] c);
        int               first;
        logic [15:0]      closer;
        qsl_pkg::t_tok    tt;
        qsl_pkg::t_result r;
        first = tokens_due.size();
        if (is_end) begin
            case (lx_mode)
                qsl_pkg::MODE_TERM:  close_tok(classify());
                qsl_pkg::MODE_SLOP:
                    close_tok(slop_cnt != 0 ? qsl_pkg::TOK_SLOP : qsl_pkg::TOK_FUZZY);
                qsl_pkg::MODE_QUOTE: flag_err(qsl_pkg::ERR_OPEN_STR);
                qsl_pkg::MODE_RIN:   flag_err(qsl_pkg::ERR_OPEN_RIN);
                qsl_pkg::MODE_REX:   flag_err(qsl_pkg::ERR_OPEN_REX);
                qsl_pkg::MODE_ESC:   flag_err(qsl_pkg::ERR_BAD_ESC);
                default: ;
            endcase
            close_tok(qsl_pkg::TOK_EOF);
            lex_reset();
        end else begin
            case (lx_mode)
                qsl_pkg::MODE_IDLE: start_char(c);
                qsl_pkg::MODE_TERM: begin
                    if (is_term_end(c)) begin
                        close_tok(classify());
                        lx_mode = qsl_pkg::MODE_IDLE;
                        start_char(c);
                    end else begin
                        feed(c);
                        if (c == "*" && lx_stars < 2'd2)
                            lx_stars = lx_stars + 2'd1;
                        if (c == "?")
                            lx_qmark = 1'b1;
                        if (c == "\\")
                            lx_mode = qsl_pkg::MODE_ESC;
                        echo(c);
                    end
                end
                qsl_pkg::MODE_ESC: begin
                    // An escaped character raises no wildcard flag, but it still becomes the final character.
                    if (is_escapable(c)) begin
                        feed(c);
                        echo(c);
                        lx_mode = qsl_pkg::MODE_TERM;
                    end else begin
                        flag_err(qsl_pkg::ERR_BAD_ESC);
                        lx_mode = qsl_pkg::MODE_ERR;
                    end
                end
                qsl_pkg::MODE_SLOP: begin
                    if (c >= "0" && c <= "9" &&
                        slop_cnt < 8'(qsl_pkg::MAX_FIELD_LEN_DEF - 2)) begin
                        slop_cnt = slop_cnt + 8'd1;
                        echo(c);
                    end else begin
                        close_tok(slop_cnt != 0 ? qsl_pkg::TOK_SLOP : qsl_pkg::TOK_FUZZY);
                        slop_cnt = '0;
                        lx_mode  = qsl_pkg::MODE_IDLE;
                        start_char(c);
                    end
                end
                qsl_pkg::MODE_QUOTE, qsl_pkg::MODE_RIN, qsl_pkg::MODE_REX: begin
                    closer = (lx_mode == qsl_pkg::MODE_QUOTE) ? "\""
                           : (lx_mode == qsl_pkg::MODE_RIN ? "]" : "}");
                    tt = (lx_mode == qsl_pkg::MODE_QUOTE) ? qsl_pkg::TOK_QUOTED :
                         (lx_mode == qsl_pkg::MODE_RIN ? qsl_pkg::TOK_RANGEIN
                                                       : qsl_pkg::TOK_RANGEEX);
                    if (c == closer) begin
                        put(1'b1, c, 1'b1, tt, qsl_pkg::ERR_NONE);
                        lx_mode = qsl_pkg::MODE_IDLE;
                    end else begin
                        echo(c);
                    end
                end
                default: ;
            endcase
        end
        if (tokens_due.size() > first) begin
            r = tokens_due[tokens_due.size() - 1];
            r.last_result = 1'b1;
            tokens_due[tokens_due.size() - 1] = r;
        end
    endfunction

    // ------------------------------------------------------------ checking

    function automatic void log_miss(string why, qsl_pkg::t_result want,
                                     qsl_pkg::t_result got);
        miss_count++;
        if (miss_count <= 10)
            $display({"%s: expected cv=%0b ch=%h end=%0b tok=%0d err=%0d last=%0b, ",
                      "actual cv=%0b ch=%h end=%0b tok=%0d err=%0d last=%0b tdata=%h"},
                     why, want.char_valid, want.out_char, want.token_end, want.token_type,
                     want.error_code, want.last_result, got.char_valid, got.out_char,
                     got.token_end, got.token_type, got.error_code, got.last_result,
                     m_axis_tdata);
    endfunction

    function automatic void check_result();
        qsl_pkg::t_result got;
        qsl_pkg::t_result want;
        got.char_valid  = m_axis_tdata[0];
        got.out_char    = m_axis_tdata[16:1];
        got.token_end   = m_axis_tdata[17];
        got.token_type  = qsl_pkg::t_tok'(m_axis_tdata[22:18]);
        got.error_code  = qsl_pkg::t_err'(m_axis_tdata[25:23]);
        got.last_result = m_axis_tlast;
        if (tokens_due.size() == 0) begin
            want = '0;
            log_miss("unexpected result", want, got);
            return;
        end
        want = tokens_due.pop_front();
        if (got.char_valid !== want.char_valid || got.out_char !== want.out_char ||
            got.token_end !== want.token_end || got.token_type !== want.token_type ||
            got.error_code !== want.error_code || got.last_result !== want.last_result ||
            m_axis_tdata[qsl_pkg::M_TDATA_W-1:qsl_pkg::RES_BITS] !== '0)
            log_miss("mismatch", want, got);
    endfunction

    // Result side: check every transaction and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 18);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------ stimulus

    // Sends one item; valid stays high afterwards so a following call can reuse it.
    task automatic send_item(input logic is_end, input logic [15:0] code);
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= is_end;
        do @(posedge i_clk); while (!s_axis_tready);
        if (is_end || lx_mode != qsl_pkg::MODE_ERR)
            live_items++;
        lex_step(is_end, code);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_item(1'b0, {8'h00, s[k]});
    endtask

    function automatic logic [15:0] pick(string s);
        return {8'h00, s[$urandom_range(0, s.len() - 1)]};
    endfunction

    function automatic logic [15:0] term_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ");
        if (r < 60)
            return pick("0123456789");
        if (r < 68)
            return "*";
        if (r < 74)
            return "?";
        if (r < 80)
            return pick("&|");
        if (r < 90)
            return 16'($urandom_range(0, 127));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] body_char(logic [15:0] closer);
        logic [15:0] c;
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(32, 126));
        return (c == closer) ? "x" : c;
    endfunction

    // One query: a run of random tokens, mostly well formed, then the end item.
    task automatic random_query();
        int          n_tok, j, k, len, kind;
        string       w;
        logic [15:0] ch, closer;
        n_tok = $urandom_range(1, 8);
        for (j = 0; j < n_tok; j++) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                send_item(1'b0, pick("+-()!:^"));
            end else if (kind < 40) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(1'b0, "\\");
                        send_item(1'b0, ($urandom_range(0, 15) == 0) ? pick("aZ5 ")
                                        : pick("\\+-!():^[]{}\"~*"));
                    end else begin
                        send_item(1'b0, term_char());
                    end
                end
            end else if (kind < 50) begin
                case ($urandom_range(0, 7))
                    0: w = "and";
                    1: w = "or";
                    2: w = "not";
                    3: w = "&&";
                    4: w = "||";
                    5: w = "andor";
                    6: w = "no";
                    default: w = "|&";
                endcase
                for (k = 0; k < w.len(); k++) begin
                    ch = {8'h00, w[k]};
                    if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1)
                        ch = ch - 16'd32;
                    send_item(1'b0, ch);
                end
            end else if (kind < 58) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_item(1'b0, pick("abcXYZ019"));
                send_item(1'b0, "*");
                if ($urandom_range(0, 4) == 0)
                    send_item(1'b0, pick("q*?7"));
            end else if (kind < 66) begin
                send_item(1'b0, "~");
                len = $urandom_range(0, 4);
                for (k = 0; k < len; k++)
                    send_item(1'b0, pick("0123456789"));
            end else if (kind < 86) begin
                case ($urandom_range(0, 2))
                    0: begin send_item(1'b0, "\""); closer = "\""; end
                    1: begin send_item(1'b0, "["); closer = "]"; end
                    default: begin send_item(1'b0, "{"); closer = "}"; end
                endcase
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                    send_item(1'b0, body_char(closer));
                if ($urandom_range(0, 99) < 85)
                    send_item(1'b0, closer);
            end else if (kind < 94) begin
                send_item(1'b0, pick("\t\n\v\f\r "));
            end else if (kind < 97) begin
                send_item(1'b0, 16'($urandom_range(0, 65535)));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(1'b0, pick("]}*"));
                end else begin
                    send_item(1'b0, "\\");
                    send_item(1'b0, pick("az09?"));
                end
            end
            if ($urandom_range(0, 1) == 0)
                send_item(1'b0, pick("\t\n\v\f\r "));
        end
        send_item(1'b1, 16'($urandom_range(0, 65535)));
    endtask

    // --------------------------------------------------------------- tests

    task automatic test_operators();
        send_text(" +-()!:^");
        send_item(1'b1, 16'hFFFF);
    endtask

    // A term of the lowest and highest codes, closed by an operator.
    task automatic test_code_extremes();
        send_item(1'b0, 16'h0000);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, "(");
        send_item(1'b1, 16'h0000);
    endtask

    task automatic test_stray_closer();
        send_text("]x");
        send_item(1'b1, 16'h5A5A);
    endtask

    task automatic test_bad_escape();
        send_text("\\q");
        send_item(1'b1, 16'hA5A5);
        send_text("\\");
        send_item(1'b1, 16'h0001);
    endtask

    // One digit past the slop bound closes the slop and starts a number.
    task automatic test_slop_bound();
        int k;
        send_item(1'b0, "~");
        for (k = 0; k < qsl_pkg::MAX_FIELD_LEN_DEF - 1; k++)
            send_item(1'b0, pick("0123456789"));
        send_item(1'b1, 16'h8000);
    endtask

    task automatic test_mixed_queries(input int n_items);
        int target;
        target = live_items + n_items;
        while (live_items < target)
            random_query();
    endtask

    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        random_query();
    endtask

    task automatic test_quiet_tail(input int n_items);
        bursts_on <= 1'b0;
        test_mixed_queries(n_items);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        bursts_on <= 1'b1;
        test_operators();
        test_code_extremes();
        test_stray_closer();
        test_bad_escape();
        test_slop_bound();
        test_mixed_queries(300);
        test_drain_pause();
        test_quiet_tail(100);
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (miss_count == 0 && tokens_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
hdl/qsl_pkg.sv
hdl/qsl_core.sv
hdl/qsl_rbuf.sv
hdl/query_string_lexer.sv
sim/query_string_lexer_tb.sv
